// ===== sv/assert_macros.svh =====
// Assertion macros for the checker file of the tile map scroll refresh block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CHK_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CHK_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== sv/tmsr_pkg.sv =====
// Package with shared types, constants and the clamp function of the scroll refresh block.
`default_nettype none
package tmsr_pkg;

  localparam int RING_TILES = 32;
  localparam int TILE_SHIFT = 3;
  localparam int RING_BITS  = $clog2(RING_TILES);

  localparam int POS_W   = 15;
  localparam int PAGE_W  = 10;
  localparam int PITCH_W = 13;
  localparam int REQ_W   = 16;
  localparam int SRC_W   = 24;
  localparam int DST_W   = 2 * RING_BITS;
  localparam int TILE_W  = POS_W - TILE_SHIFT;
  localparam int COORD_W = TILE_W + 1;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 15;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_X_MIN   = 3'd0,
    REG_X_MAX   = 3'd1,
    REG_X_PAGE  = 3'd2,
    REG_Y_MIN   = 3'd3,
    REG_Y_MAX   = 3'd4,
    REG_Y_PAGE  = 3'd5,
    REG_MAP_W   = 3'd6,
    REG_UNUSED  = 3'd7
  } cfg_reg_t;

  // Controller to datapath.
  typedef struct packed {
    logic capture;
    logic clamp;
    logic plan;
    logic mul;
    logic load;
    logic emit_copy;
    logic emit_none;
    logic last;
    logic row_phase;
  } tmsr_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic move_x;
    logic move_y;
    logic k_last;
    logic out_free;
  } tmsr_sts_t;

  // Clamp one axis: upper bound first, then the lower bound, then floor at zero.
  function automatic logic [POS_W-1:0] clamp_axis(input logic signed [REQ_W-1:0] req,
                                                   input logic [POS_W-1:0] lo,
                                                   input logic [POS_W-1:0] hi,
                                                   input logic [PAGE_W-1:0] page);
    logic signed [REQ_W:0] bound;
    logic signed [REQ_W:0] r17;
    logic signed [REQ_W:0] lo17;
    logic signed [REQ_W:0] t;
    bound = $signed({2'b00, hi}) - $signed({7'b0000000, page});
    r17   = $signed({req[REQ_W-1], req});
    lo17  = $signed({2'b00, lo});
    if (r17 >= bound) begin
      t = bound - 17'sd1;
    end else if (r17 < lo17) begin
      t = lo17;
    end else begin
      t = r17;
    end
    if (t[REQ_W]) begin
      return '0;
    end
    return t[POS_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== sv/tile_map_scroll_refresh.sv =====
// Top level of the tile map scroll refresh block: controller plus datapath.
// After an item is accepted the controller steps through clamp, plan, decide, multiply and
// load, then emits one copy command per cycle into the output register unless the output
// stalls; a no-copy result goes from decide to the no-copy state. No new item is taken until
// the last command of the current one is emitted. Synchronous active-low reset restores the
// default registers, clears the previous position to zero and empties the output register.
`default_nettype none
module tile_map_scroll_refresh (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // Configuration write port; the index follows the register list.
  input  wire logic                              cfg_we,
  input  wire logic [tmsr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [tmsr_pkg::CFG_DATA_W-1:0]   cfg_data,
  // Requested viewport position, one item per update.
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic signed [tmsr_pkg::REQ_W-1:0] in_req_x,
  input  wire logic signed [tmsr_pkg::REQ_W-1:0] in_req_y,
  // Copy commands, each carrying the new scroll offsets.
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic                                   out_has_copy,
  output logic [tmsr_pkg::SRC_W-1:0]             out_src_index,
  output logic [tmsr_pkg::DST_W-1:0]             out_dst_index,
  output logic [tmsr_pkg::POS_W-1:0]             out_scroll_x,
  output logic [tmsr_pkg::POS_W-1:0]             out_scroll_y,
  output logic                                   out_last
);
  import tmsr_pkg::*;

  // The controller walks each item through clamp, planning, a base address
  // multiply and then the emission loop. A column refresh steps the source
  // index by the map pitch, a row refresh steps it by one, so the only
  // multiplier in the design runs once per edge.
  tmsr_cmd_t cmd;
  tmsr_sts_t sts;

  tmsr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath owns the registers, the stored previous position and the
  // output register, which holds a finished command while the consumer stalls.
  tmsr_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_req_x      (in_req_x),
    .in_req_y      (in_req_y),
    .cmd           (cmd),
    .sts           (sts),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .out_has_copy  (out_has_copy),
    .out_src_index (out_src_index),
    .out_dst_index (out_dst_index),
    .out_scroll_x  (out_scroll_x),
    .out_scroll_y  (out_scroll_y),
    .out_last      (out_last)
  );

endmodule
`default_nettype wire

// ===== sv/tmsr_ctrl.sv =====
// Controller state machine that sequences clamp, planning and copy command emission.
`default_nettype none
module tmsr_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  tmsr_pkg::tmsr_sts_t     sts,
  output tmsr_pkg::tmsr_cmd_t     cmd
);
  import tmsr_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLAMP,
    S_PLAN,
    S_DECIDE,
    S_MUL,
    S_LOAD,
    S_EMIT,
    S_NONE
  } state_t;

  state_t state_r, state_nxt;
  logic   row_r, row_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    row_nxt       = row_r;
    cmd           = '0;
    cmd.row_phase = row_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_CLAMP;
        end
      end
      S_CLAMP: begin
        cmd.clamp = 1'b1;
        state_nxt = S_PLAN;
      end
      S_PLAN: begin
        cmd.plan  = 1'b1;
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        if (sts.move_x) begin
          row_nxt   = 1'b0;
          state_nxt = S_MUL;
        end else if (sts.move_y) begin
          row_nxt   = 1'b1;
          state_nxt = S_MUL;
        end else begin
          state_nxt = S_NONE;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        cmd.load  = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit_copy = 1'b1;
          cmd.last      = sts.k_last && (row_r || !sts.move_y);
          if (sts.k_last) begin
            if (!row_r && sts.move_y) begin
              row_nxt   = 1'b1;
              state_nxt = S_MUL;
            end else begin
              state_nxt = S_IDLE;
            end
          end
        end
      end
      S_NONE: begin
        if (sts.out_free) begin
          cmd.emit_none = 1'b1;
          cmd.last      = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      row_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      row_r   <= row_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== sv/tmsr_dp.sv =====
// Datapath with configuration registers, clamp, tile planning, index generation and output stage.
`default_nettype none
module tmsr_dp (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [tmsr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [tmsr_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire logic signed [tmsr_pkg::REQ_W-1:0] in_req_x,
  input  wire logic signed [tmsr_pkg::REQ_W-1:0] in_req_y,
  input  tmsr_pkg::tmsr_cmd_t                    cmd,
  output tmsr_pkg::tmsr_sts_t                    sts,
  input  wire logic                              out_stall,
  output logic                                   out_valid,
  output logic                                   out_has_copy,
  output logic [tmsr_pkg::SRC_W-1:0]             out_src_index,
  output logic [tmsr_pkg::DST_W-1:0]             out_dst_index,
  output logic [tmsr_pkg::POS_W-1:0]             out_scroll_x,
  output logic [tmsr_pkg::POS_W-1:0]             out_scroll_y,
  output logic                                   out_last
);
  import tmsr_pkg::*;

  logic [POS_W-1:0]   x_min_r, x_max_r, y_min_r, y_max_r;
  logic [PAGE_W-1:0]  x_page_r, y_page_r;
  logic [PITCH_W-1:0] pitch_r;

  logic signed [REQ_W-1:0] req_x_r, req_y_r;
  logic [POS_W-1:0]   sx_r, sy_r, prev_x_r, prev_y_r;
  logic               move_x_r, move_y_r;
  logic [COORD_W-1:0] tx_r, ty_r;
  logic [SRC_W-1:0]   prod_r, src_r;
  logic [RING_BITS-1:0] k_r;

  logic               out_valid_r, out_has_copy_r, out_last_r;
  logic [SRC_W-1:0]   out_src_r;
  logic [DST_W-1:0]   out_dst_r;
  logic [POS_W-1:0]   out_sx_r, out_sy_r;

  logic [TILE_W-1:0]  tvx, tvy, tbx, tby;
  logic [COORD_W-1:0] mul_a;
  logic [2*PITCH_W-1:0] prod_full;
  logic [RING_BITS-1:0] ring_lo;
  logic [DST_W-1:0]   dst_cur;
  logic               out_free;

  assign tvx = sx_r[POS_W-1:TILE_SHIFT];
  assign tvy = sy_r[POS_W-1:TILE_SHIFT];
  assign tbx = prev_x_r[POS_W-1:TILE_SHIFT];
  assign tby = prev_y_r[POS_W-1:TILE_SHIFT];

  assign mul_a     = cmd.row_phase ? ty_r : {1'b0, tvy};
  assign prod_full = mul_a * pitch_r;

  // Ring coordinate of the walking axis.
  assign ring_lo = cmd.row_phase ? (tvx[RING_BITS-1:0] + k_r) : (tvy[RING_BITS-1:0] + k_r);
  assign dst_cur = cmd.row_phase ? {ty_r[RING_BITS-1:0], ring_lo}
                                 : {ring_lo, tx_r[RING_BITS-1:0]};

  assign out_free = !out_valid_r || !out_stall;

  assign sts.move_x   = move_x_r;
  assign sts.move_y   = move_y_r;
  assign sts.k_last   = &k_r;
  assign sts.out_free = out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_min_r  <= '0;
      x_max_r  <= POS_W'(512);
      x_page_r <= PAGE_W'(240);
      y_min_r  <= '0;
      y_max_r  <= POS_W'(512);
      y_page_r <= PAGE_W'(160);
      pitch_r  <= PITCH_W'(64);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_X_MIN:  x_min_r  <= cfg_data;
        REG_X_MAX:  x_max_r  <= cfg_data;
        REG_X_PAGE: x_page_r <= cfg_data[PAGE_W-1:0];
        REG_Y_MIN:  y_min_r  <= cfg_data;
        REG_Y_MAX:  y_max_r  <= cfg_data;
        REG_Y_PAGE: y_page_r <= cfg_data[PAGE_W-1:0];
        REG_MAP_W:  pitch_r  <= cfg_data[PITCH_W-1:0];
        REG_UNUSED: ;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_x_r <= '0;
      prev_y_r <= '0;
      move_x_r <= 1'b0;
      move_y_r <= 1'b0;
    end else if (cmd.plan) begin
      move_x_r <= (tvx != tbx);
      move_y_r <= (tvy != tby);
      prev_x_r <= sx_r;
      prev_y_r <= sy_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_x_r <= in_req_x;
      req_y_r <= in_req_y;
    end
    if (cmd.clamp) begin
      sx_r <= clamp_axis(req_x_r, x_min_r, x_max_r, x_page_r);
      sy_r <= clamp_axis(req_y_r, y_min_r, y_max_r, y_page_r);
    end
    if (cmd.plan) begin
      // Moving to a lower tile refreshes the near edge, moving to a higher tile the far edge of the ring.
      tx_r <= (tvx < tbx) ? {1'b0, tvx} : ({1'b0, tvx} + COORD_W'(RING_TILES - 1));
      ty_r <= (tvy < tby) ? {1'b0, tvy} : ({1'b0, tvy} + COORD_W'(RING_TILES - 1));
    end
    if (cmd.mul) begin
      prod_r <= prod_full[SRC_W-1:0];
    end
    if (cmd.load) begin
      src_r <= prod_r + (cmd.row_phase ? SRC_W'(tvx) : SRC_W'(tx_r));
      k_r   <= '0;
    end else if (cmd.emit_copy) begin
      src_r <= src_r + (cmd.row_phase ? SRC_W'(1) : SRC_W'(pitch_r));
      k_r   <= k_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_copy || cmd.emit_none) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_copy || cmd.emit_none) begin
      out_has_copy_r <= cmd.emit_copy;
      out_src_r      <= cmd.emit_copy ? src_r : '0;
      out_dst_r      <= cmd.emit_copy ? dst_cur : '0;
      out_sx_r       <= sx_r;
      out_sy_r       <= sy_r;
      out_last_r     <= cmd.last;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_has_copy  = out_has_copy_r;
  assign out_src_index = out_src_r;
  assign out_dst_index = out_dst_r;
  assign out_scroll_x  = out_sx_r;
  assign out_scroll_y  = out_sy_r;
  assign out_last      = out_last_r;

endmodule
`default_nettype wire

// ===== sv/tmsr_chk.sv =====
// Port-level checker for the scroll refresh block and its bind to the top level.
`default_nettype none
`include "assert_macros.svh"
module tmsr_chk (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_valid,
  input wire logic                              in_stall,
  input wire logic                              out_valid,
  input wire logic                              out_stall,
  input wire logic                              out_has_copy,
  input wire logic [tmsr_pkg::SRC_W-1:0]        out_src_index,
  input wire logic [tmsr_pkg::DST_W-1:0]        out_dst_index,
  input wire logic [tmsr_pkg::POS_W-1:0]        out_scroll_x,
  input wire logic [tmsr_pkg::POS_W-1:0]        out_scroll_y,
  input wire logic                              out_last
);

  logic                         none_ok;
  logic                         out_take;
  logic [2*tmsr_pkg::POS_W-1:0] scroll_pair;

  assign none_ok     = out_last && (out_src_index == '0) && (out_dst_index == '0);
  assign out_take    = out_valid && !out_stall;
  assign scroll_pair = {out_scroll_x, out_scroll_y};

  // A stalled result stays offered.
  `CHK_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)

  // The no-copy result is the only result of its item and carries zero indexes.
  `CHK_SAME(a_none_form, clk, rst_n, out_valid && !out_has_copy, none_ok)

  // Once an item is taken the block works on it before taking another.
  `CHK_NEXT(a_busy, clk, rst_n, in_valid && !in_stall, in_stall)

  // All results of one item carry the same scroll offsets.
  `CHK_NEXT(a_scroll_same, clk, rst_n, out_take && !out_last, $stable(scroll_pair))

endmodule

bind tile_map_scroll_refresh tmsr_chk u_tmsr_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_has_copy  (out_has_copy),
  .out_src_index (out_src_index),
  .out_dst_index (out_dst_index),
  .out_scroll_x  (out_scroll_x),
  .out_scroll_y  (out_scroll_y),
  .out_last      (out_last)
);
`default_nettype wire
